/* rtl/ddd_pkg.sv */
`timescale 1ns / 1ps

package ddd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 23;

  // number of days in the calendar counts (365 * year and up)
  localparam int COUNT_W = 23;

  // ceil(year / 100) through (year + 99) * 5243 >> 19, exact for 15-bit sums
  localparam int              RECIP_W     = 13;
  localparam logic [12:0]     RECIP_100   = 13'd5243;
  localparam int              RECIP_SHIFT = 19;
  localparam int              CENT_W      = 8;

  localparam logic signed [DIFF_W:0] DIFF_LIMIT = 24'sd3652500;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // days in the year before the first of the month
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // month length, zero for month codes outside the calendar
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/ddd_in_if.sv */
`timescale 1ns / 1ps

interface ddd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ddd_pkg::DAY_W-1:0]     first_day;
  logic [ddd_pkg::MONTH_W-1:0]   first_month;
  logic [ddd_pkg::YEAR_W-1:0]    first_year;
  logic [ddd_pkg::DAY_W-1:0]     second_day;
  logic [ddd_pkg::MONTH_W-1:0]   second_month;
  logic [ddd_pkg::YEAR_W-1:0]    second_year;

  modport source (output valid, first_day, first_month, first_year,
                  second_day, second_month, second_year, input ready);
  modport sink (input valid, first_day, first_month, first_year,
                second_day, second_month, second_year, output ready);
endinterface

/* rtl/ddd_out_if.sv */
`timescale 1ns / 1ps

interface ddd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddd_pkg::DIFF_W-1:0]  day_difference;
  logic                               dates_valid;

  modport source (output valid, day_difference, dates_valid, input ready);
  modport sink (input valid, day_difference, dates_valid, output ready);
endinterface

/* rtl/date_difference_days.sv */
`timescale 1ns / 1ps
// each accepted request passes through stages s1, s2, s3 and s4 to out_req
// throughput: one date pair per cycle while out_req.ready is high; each of the four
//   register stages advances whenever it is empty or the stage after it moves on
// reset: synchronous active-high rst clears the stage valid bits only;
//   payload registers are not reset

module date_difference_days (
  input  logic       clk,
  input  logic       rst,
  ddd_in_if.sink     in_req,
  ddd_out_if.source  out_req
);

  localparam int DAY_W   = ddd_pkg::DAY_W;
  localparam int MONTH_W = ddd_pkg::MONTH_W;
  localparam int YEAR_W  = ddd_pkg::YEAR_W;
  localparam int CENT_W  = ddd_pkg::CENT_W;
  localparam int COUNT_W = ddd_pkg::COUNT_W;
  localparam int DIFF_W  = ddd_pkg::DIFF_W;
  localparam int PROD_W  = YEAR_W + 1 + ddd_pkg::RECIP_W;
  localparam int LEAPS_W = YEAR_W - 1;

  // stage 1: date fields plus the number of centuries begun, ceil(y / 100)
  typedef struct packed {
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [CENT_W-1:0]  cent;
  } s1_date_t;

  // stage 2: leap facts, table lookups and legality
  typedef struct packed {
    logic [DAY_W-1:0]   d;
    logic               late_leap;  // month after february in a leap year
    logic [YEAR_W-1:0]  y;
    logic [LEAPS_W-1:0] leaps;      // leap days in years before y
    logic [8:0]         dbm;
    logic               ok;
  } s2_date_t;

  // ------------------------------------------------------------------
  // stage handshake: a stage moves when empty or when its successor moves
  // ------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_adv, s2_adv, s3_adv, s4_adv;

  assign s4_adv = !s4_valid || out_req.ready;
  assign s3_adv = !s3_valid || s4_adv;
  assign s2_adv = !s2_valid || s3_adv;
  assign s1_adv = !s1_valid || s2_adv;

  assign in_req.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= in_req.valid;
      if (s2_adv) s2_valid <= s1_valid;
      if (s3_adv) s3_valid <= s2_valid;
      if (s4_adv) s4_valid <= s3_valid;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: reciprocal multiply for ceil(y / 100)
  // ------------------------------------------------------------------
  function automatic logic [CENT_W-1:0] centuries(input logic [YEAR_W-1:0] y);
    logic [YEAR_W:0]   x;
    logic [PROD_W-1:0] p;
    x = {1'b0, y} + (YEAR_W + 1)'(99);
    p = PROD_W'(x) * PROD_W'(ddd_pkg::RECIP_100);
    return p[ddd_pkg::RECIP_SHIFT +: CENT_W];
  endfunction

  s1_date_t s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_a.d    <= in_req.first_day;
      s1_a.m    <= in_req.first_month;
      s1_a.y    <= in_req.first_year;
      s1_a.cent <= centuries(in_req.first_year);
      s1_b.d    <= in_req.second_day;
      s1_b.m    <= in_req.second_month;
      s1_b.y    <= in_req.second_year;
      s1_b.cent <= centuries(in_req.second_year);
    end
  end

  // ------------------------------------------------------------------
  // stage 2: leap year, leap days before the year, month tables
  // ------------------------------------------------------------------
  function automatic s2_date_t classify(input s1_date_t s);
    s2_date_t           r;
    logic [YEAR_W:0]    hund;
    logic [YEAR_W:0]    y3;
    logic [CENT_W:0]    c3;
    logic               on_century;
    logic               leap;
    logic [DAY_W-1:0]   len;
    // ceil(y/100) * 100 equals y exactly on a century year
    hund       = (YEAR_W + 1)'(s.cent) * (YEAR_W + 1)'(100);
    on_century = (hund == {1'b0, s.y});
    // on a century year cent is y / 100, so divisible by 400 means cent % 4 == 0
    leap       = on_century ? (s.cent[1:0] == 2'd0) : (s.y[1:0] == 2'd0);
    y3         = {1'b0, s.y} + (YEAR_W + 1)'(3);
    c3         = {1'b0, s.cent} + (CENT_W + 1)'(3);
    // ceil(y/4) - ceil(y/100) + ceil(y/400), with ceil(y/400) = ceil(ceil(y/100)/4)
    r.leaps    = y3[YEAR_W:2] - LEAPS_W'(s.cent) + LEAPS_W'(c3[CENT_W:2]);
    len        = ddd_pkg::month_length(s.m, leap);
    r.d        = s.d;
    r.y        = s.y;
    r.late_leap = leap && (s.m > ddd_pkg::MONTH_FEB);
    r.dbm      = ddd_pkg::days_before(s.m);
    r.ok       = (s.m >= ddd_pkg::MONTH_JAN) && (s.m <= ddd_pkg::MONTH_DEC) &&
                 (s.d != '0) && (s.d <= len);
    return r;
  endfunction

  s2_date_t s2_a, s2_b;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_a <= classify(s1_a);
      s2_b <= classify(s1_b);
    end
  end

  // ------------------------------------------------------------------
  // stage 3: absolute day numbers
  // ------------------------------------------------------------------
  function automatic logic [COUNT_W-1:0] day_number(input s2_date_t s);
    return COUNT_W'(s.y) * COUNT_W'(365) + COUNT_W'(s.leaps) + COUNT_W'(s.dbm) +
           COUNT_W'(s.d) + COUNT_W'(s.late_leap);
  endfunction

  logic [COUNT_W-1:0] s3_num_a, s3_num_b;
  logic               s3_ok;

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_num_a <= day_number(s2_a);
      s3_num_b <= day_number(s2_b);
      s3_ok    <= s2_a.ok && s2_b.ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 4: subtract, saturate, zero on an illegal date
  // ------------------------------------------------------------------
  logic signed [DIFF_W:0]   raw_diff;
  logic signed [DIFF_W-1:0] diff_next;

  always_comb begin
    raw_diff = $signed({1'b0, s3_num_b}) - $signed({1'b0, s3_num_a});
    priority if (!s3_ok) begin
      diff_next = '0;
    end else if (raw_diff > ddd_pkg::DIFF_LIMIT) begin
      diff_next = DIFF_W'(ddd_pkg::DIFF_LIMIT);
    end else if (raw_diff < -ddd_pkg::DIFF_LIMIT) begin
      diff_next = DIFF_W'(-ddd_pkg::DIFF_LIMIT);
    end else begin
      diff_next = raw_diff[DIFF_W-1:0];
    end
  end

  logic signed [DIFF_W-1:0] s4_diff;
  logic                     s4_ok;

  always_ff @(posedge clk) begin
    if (s4_adv) begin
      s4_diff <= diff_next;
      s4_ok   <= s3_ok;
    end
  end

  assign out_req.valid          = s4_valid;
  assign out_req.day_difference = s4_diff;
  assign out_req.dates_valid    = s4_ok;

endmodule

/* rtl/ddd_checker.sv */
`timescale 1ns / 1ps

module ddd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ddd_pkg::DIFF_W-1:0] day_difference,
  input logic                              dates_valid
);

  localparam logic signed [ddd_pkg::DIFF_W-1:0] LIMIT =
    ddd_pkg::DIFF_W'(ddd_pkg::DIFF_LIMIT);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_difference) &&
                                $stable(dates_valid))
    else $error("stalled result changed");

  // illegal dates give a zero difference
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dates_valid |-> day_difference == '0)
    else $error("nonzero difference on illegal date");

  // difference stays within the saturation bounds
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day_difference <= LIMIT) && (day_difference >= -LIMIT))
    else $error("difference out of range");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // input is open whenever the output is empty or draining
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with output empty or draining");

endmodule

bind date_difference_days ddd_checker u_ddd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_req.ready),
  .out_valid      (out_req.valid),
  .out_ready      (out_req.ready),
  .day_difference (out_req.day_difference),
  .dates_valid    (out_req.dates_valid)
);

/* sim/ddd_diff_checker.sv */
`timescale 1ns / 1ps

module ddd_diff_checker (
  input  logic clk,
  input  logic rst,
  ddd_in_if    in_req,
  ddd_out_if   out_req,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   invalid_seen,
  output int   clipped_seen
);

  localparam int SPAN_BOUND = 3652500;

  typedef struct packed {
    logic signed [ddd_pkg::DIFF_W-1:0] span;
    logic                              ok;
    logic                              clipped;
  } span_t;

  span_t span_queue[$];
  span_t head;
  int    errors_n;
  int    checked_n;
  int    invalid_n;
  int    clipped_n;

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // zero for month codes outside 1..12, so any day fails against it
  function automatic int days_in(input int m, input int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // running day count from the start of year zero
  function automatic int day_index(input int d, input int m, input int y);
    int n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
    for (int k = 1; k < m; k++) begin
      n += days_in(k, 1);
    end
    if (m > 2 && is_leap(y)) n++;
    return n;
  endfunction

  function automatic span_t predict_span(input int d1, input int m1, input int y1,
                                         input int d2, input int m2, input int y2);
    span_t r;
    int    diff;
    r = '0;
    if (d1 >= 1 && d1 <= days_in(m1, y1) && d2 >= 1 && d2 <= days_in(m2, y2)) begin
      r.ok = 1'b1;
      diff = day_index(d2, m2, y2) - day_index(d1, m1, y1);
      if (diff > SPAN_BOUND) begin
        diff = SPAN_BOUND;
        r.clipped = 1'b1;
      end else if (diff < -SPAN_BOUND) begin
        diff = -SPAN_BOUND;
        r.clipped = 1'b1;
      end
      r.span = ddd_pkg::DIFF_W'(diff);
    end
    return r;
  endfunction

  initial begin
    errors_n     = 0;
    checked_n    = 0;
    invalid_n    = 0;
    clipped_n    = 0;
    fail_count   = 0;
    pending      = 0;
    checked      = 0;
    invalid_seen = 0;
    clipped_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      // results leave first: a result always belongs to an earlier request
      if (out_req.valid && out_req.ready) begin
        if (span_queue.size() == 0) begin
          $error("result with no request outstanding");
          errors_n++;
        end else begin
          head = span_queue.pop_front();
          checked_n++;
          if (out_req.dates_valid !== head.ok) begin
            $error("dates_valid: expected %0d, got %0d", head.ok, out_req.dates_valid);
            errors_n++;
          end
          if (out_req.day_difference !== head.span) begin
            $error("day_difference: expected %0d, got %0d", head.span,
                   out_req.day_difference);
            errors_n++;
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        head = predict_span(in_req.first_day, in_req.first_month, in_req.first_year,
                            in_req.second_day, in_req.second_month, in_req.second_year);
        if (!head.ok) invalid_n++;
        if (head.clipped) clipped_n++;
        span_queue.push_back(head);
      end
    end
    fail_count   <= errors_n;
    pending      <= span_queue.size();
    checked      <= checked_n;
    invalid_seen <= invalid_n;
    clipped_seen <= clipped_n;
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASES       = 5;
  localparam int HOLD_BURST   = 40;   // requests offered while the output is held off
  localparam int LONG_HOLD    = 80;   // cycles of the long output hold-off
  localparam int DRAIN_CYCLES = 12;   // pipeline is 4 deep, leave some margin
  localparam int MAX_YEAR     = 16383;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // quiet: no gaps on either side; hold_req: ask the receiver for a long hold-off
  bit   quiet;
  bit   hold_req;
  int   sent;

  int   fail_count;
  int   pending;
  int   checked;
  int   invalid_seen;
  int   clipped_seen;

  ddd_in_if  in_req();
  ddd_out_if out_req();

  date_difference_days u_top (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_req (out_req)
  );

  // watches both channels, predicts every request and compares the results
  ddd_diff_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_req       (in_req),
    .out_req      (out_req),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .invalid_seen (invalid_seen),
    .clipped_seen (clipped_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit leap_of(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_pair(input int d1, input int m1, input int y1,
                           input int d2, input int m2, input int y2);
    int gap;
    gap = quiet ? 0 : idle_len();
    // valid only drops when a gap follows, so it never toggles within a step
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.first_day    <= d1[ddd_pkg::DAY_W-1:0];
    in_req.first_month  <= m1[ddd_pkg::MONTH_W-1:0];
    in_req.first_year   <= y1[ddd_pkg::YEAR_W-1:0];
    in_req.second_day   <= d2[ddd_pkg::DAY_W-1:0];
    in_req.second_month <= m2[ddd_pkg::MONTH_W-1:0];
    in_req.second_year  <= y2[ddd_pkg::YEAR_W-1:0];
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent++;
  endtask

  // a legal date, mostly in the usual year range, sometimes up to the full field
  task automatic pick_date(output int d, output int m, output int y);
    int len;
    y   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9999) : $urandom_range(0, MAX_YEAR);
    m   = $urandom_range(1, 12);
    len = ddd_pkg::month_length(m[ddd_pkg::MONTH_W-1:0], leap_of(y));
    // last day of the month is where the table and leap logic are most exposed
    d   = ($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len);
  endtask

  // break one date: bad month code, day zero, or a day past a short month
  task automatic corrupt(inout int d, inout int m);
    case ($urandom_range(0, 2))
      0: m = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 15);
      1: d = 0;
      default: begin
        case ($urandom_range(0, 4))
          0:       m = 2;
          1:       m = 4;
          2:       m = 6;
          3:       m = 9;
          default: m = 11;
        endcase
        d = (m == 2) ? $urandom_range(29, 31) : 31;
      end
    endcase
  endtask

  task automatic send_random();
    int d1, m1, y1, d2, m2, y2;
    int r, len;
    r = $urandom_range(0, 99);
    pick_date(d1, m1, y1);
    pick_date(d2, m2, y2);
    if (r < 15) begin
      // close pair: same year or neighbors, in either order
      y2  = ($urandom_range(0, 1) != 0) ? (y1 ^ 1) : y1;
      len = ddd_pkg::month_length(m2[ddd_pkg::MONTH_W-1:0], leap_of(y2));
      if (d2 > len) d2 = len;
    end else if (r < 27) begin
      if ($urandom_range(0, 1) != 0) corrupt(d1, m1);
      else corrupt(d2, m2);
    end else if (r < 40) begin
      // raw field noise, every bit of every field
      d1 = $urandom_range(0, 31);
      m1 = $urandom_range(0, 15);
      y1 = $urandom_range(0, MAX_YEAR);
      d2 = $urandom_range(0, 31);
      m2 = $urandom_range(0, 15);
      y2 = $urandom_range(0, MAX_YEAR);
    end
    send_pair(d1, m1, y1, d2, m2, y2);
  endtask

  // receiver: random stalls, quiet stretches and the long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the pipeline fills and back-pressures the input
        hold_req = 1'b0;
        out_req.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        out_req.ready <= 1'b0;
        stall_left--;
      end else if (quiet) begin
        out_req.ready <= 1'b1;
      end else begin
        out_req.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    in_req.valid        = 1'b0;
    in_req.first_day    = '0;
    in_req.first_month  = '0;
    in_req.first_year   = '0;
    in_req.second_day   = '0;
    in_req.second_month = '0;
    in_req.second_year  = '0;
    out_req.ready       = 1'b0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    sent                = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: same day, full range both ways
    send_pair(1, 1, 0, 1, 1, 0);
    send_pair(1, 1, 0, 31, 12, 9999);
    send_pair(31, 12, 9999, 1, 1, 0);
    // leap rules: century not leap, 400 leap, year zero leap
    send_pair(28, 2, 1900, 1, 3, 1900);
    send_pair(29, 2, 1900, 1, 3, 1900);
    send_pair(29, 2, 2000, 1, 3, 2000);
    send_pair(29, 2, 2024, 29, 2, 2023);
    send_pair(29, 2, 0, 1, 3, 0);
    // first date later, then earlier, than the second, across a year boundary
    send_pair(15, 3, 2021, 10, 2, 2020);
    send_pair(31, 12, 2020, 1, 1, 2021);
    // illegal dates: month codes, day zero, day past the month, all ones
    send_pair(1, 0, 2000, 1, 1, 2000);
    send_pair(1, 1, 2000, 1, 13, 2000);
    send_pair(31, 15, MAX_YEAR, 1, 1, 0);
    send_pair(0, 5, 2000, 1, 5, 2000);
    send_pair(31, 4, 2000, 1, 5, 2000);
    send_pair(31, 1, 2000, 30, 4, 2000);
    // years past 9999: right at the span limit, just past it, far past it
    send_pair(1, 1, 0, 16, 3, 10000);
    send_pair(1, 1, 0, 17, 3, 10000);
    send_pair(17, 3, 10000, 1, 1, 0);
    send_pair(1, 1, 0, 31, 12, MAX_YEAR);
    send_pair(31, 12, MAX_YEAR, 1, 1, 0);
    send_pair(31, 12, MAX_YEAR, 31, 12, MAX_YEAR);

    // random phases; phase 2 runs without gaps, odd phases open with a hold-off burst
    for (int phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 2);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (phase % 2 == 1 && i == 0) begin
          quiet    = 1'b1;
          hold_req = 1'b1;
        end
        if (phase % 2 == 1 && i == HOLD_BURST) quiet = 1'b0;
        send_random();
      end
    end
    in_req.valid <= 1'b0;

    // let the checker see the last request, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d date pairs sent, %0d results checked", sent, checked);
    $display("%0d with an illegal date, %0d clipped at the span limit",
             invalid_seen, clipped_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
